// ----- rtl/wsh_pkg.sv -----
`default_nettype none
package wsh_pkg;

   // configuration register
   localparam int CSR_BITS = 4;

   // action codes carried in the request tuser
   localparam int ACTION_BITS = 2;
   localparam logic [ACTION_BITS-1:0] ACT_SET_FRAME = 2'd0;
   localparam logic [ACTION_BITS-1:0] ACT_PICK      = 2'd1;

   // command queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_BITS   = 1;

   // classified command kinds
   typedef enum logic [1:0] {
      CMD_FRAME,
      CMD_PICK,
      CMD_REJECT
   } cmd_kind_type;

   typedef struct packed {
      logic         valid;
      cmd_kind_type kind;
   } cmd_ctrl_type;

   // result flags, hit in the lowest bit
   typedef struct packed {
      logic rejected;
      logic hit;
   } rsp_flags_type;

   typedef enum logic {
      BK_IDLE,
      BK_SEARCH
   } back_state_type;

endpackage
`default_nettype wire

// ----- rtl/window_stack_hit_test_and_raise.sv -----
// flow: each request passes through the command queue, then the back end writes the
//   result register; a pick stops at the first slot from the top that holds the point
// throughput: one frame write or reject per cycle while rsp_ready keeps up; a pick holds
//   the back end while it walks one stack slot per cycle, until a hit or a miss
// reset: synchronous, clears the window count, the command queue and the result
//   register, sets the stacking order to identity and marks all rectangles empty
`default_nettype none
module window_stack_hit_test_and_raise #(
   parameter int MAX_WINDOWS  = 8,
   parameter int COORD_BITS   = 12,
   localparam int ID_BITS     = $clog2(MAX_WINDOWS),
   localparam int CNT_BITS    = $clog2(MAX_WINDOWS + 1),
   localparam int DATA_W      = ID_BITS + 6 * COORD_BITS + 2,
   localparam int REQ_TDATA_W = ((DATA_W + 7) / 8) * 8,
   localparam int RSP_TDATA_W = ((2 * ID_BITS + 7) / 8) * 8
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   // window_id, point_x, point_y, rect_left, rect_top, rect_width, rect_height
   input  wire logic [REQ_TDATA_W-1:0]           req_tdata,
   // action
   input  wire logic [wsh_pkg::ACTION_BITS-1:0]  req_tuser,
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   // hit_window, top_window
   output logic [RSP_TDATA_W-1:0]                rsp_tdata,
   // hit, rejected
   output logic [1:0]                            rsp_tuser,
   input  wire logic                             csr_valid,
   output logic                                  csr_ready,
   input  wire logic [wsh_pkg::CSR_BITS-1:0]     csr_data
);

   logic [wsh_pkg::CSR_BITS-1:0] count_ff;
   logic [CNT_BITS-1:0]          live_count;
   wsh_pkg::cmd_ctrl_type        cmd;
   logic [DATA_W-1:0]            cmd_data;
   logic                         cmd_ready;
   wsh_pkg::rsp_flags_type       rsp_flags;
   logic [ID_BITS-1:0]           rsp_hit_window, rsp_top_window;

   // window count register
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (csr_valid) begin
         count_ff <= csr_data;
      end
   end

   // counts above capacity act as full capacity
   assign live_count = (32'(count_ff) > MAX_WINDOWS) ? CNT_BITS'(MAX_WINDOWS)
                                                     : CNT_BITS'(count_ff);

   wsh_front #(
      .ID_BITS  (ID_BITS),
      .CNT_BITS (CNT_BITS),
      .DATA_W   (DATA_W)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .live_count (live_count),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_action (req_tuser),
      .req_data   (req_tdata[DATA_W-1:0]),
      .cmd        (cmd),
      .cmd_data   (cmd_data),
      .cmd_ready  (cmd_ready)
   );

   wsh_back #(
      .MAX_WINDOWS (MAX_WINDOWS),
      .COORD_BITS  (COORD_BITS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .live_count     (live_count),
      .cmd            (cmd),
      .cmd_data       (cmd_data),
      .cmd_ready      (cmd_ready),
      .rsp_valid      (rsp_tvalid),
      .rsp_ready      (rsp_tready),
      .rsp_flags      (rsp_flags),
      .rsp_hit_window (rsp_hit_window),
      .rsp_top_window (rsp_top_window)
   );

   // result packing
   assign rsp_tdata = RSP_TDATA_W'({rsp_top_window, rsp_hit_window});
   assign rsp_tuser = rsp_flags;

endmodule
`default_nettype wire

// ----- rtl/wsh_front.sv -----
`default_nettype none
module wsh_front #(
   parameter int ID_BITS  = 3,
   parameter int CNT_BITS = 4,
   parameter int DATA_W   = 77
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic [CNT_BITS-1:0]               live_count,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   input  wire logic [wsh_pkg::ACTION_BITS-1:0]   req_action,
   input  wire logic [DATA_W-1:0]                 req_data,
   output wsh_pkg::cmd_ctrl_type                  cmd,
   output logic [DATA_W-1:0]                      cmd_data,
   input  wire logic                              cmd_ready
);

   logic [ID_BITS-1:0]                   req_id;
   wsh_pkg::cmd_kind_type                kind_class;
   wsh_pkg::cmd_kind_type                kind_mem [wsh_pkg::QUEUE_DEPTH];
   logic [DATA_W-1:0]                    data_mem [wsh_pkg::QUEUE_DEPTH];
   logic [wsh_pkg::QPTR_BITS-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [wsh_pkg::QPTR_BITS-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [wsh_pkg::QPTR_BITS:0]          fill_ff, fill_in;
   logic                                 push, pop;

   // classify the incoming transaction
   assign req_id = req_data[ID_BITS-1:0];

   always_comb begin
      case (req_action)
         wsh_pkg::ACT_SET_FRAME: begin
            kind_class = (CNT_BITS'(req_id) < live_count) ? wsh_pkg::CMD_FRAME
                                                            : wsh_pkg::CMD_REJECT;
         end
         wsh_pkg::ACT_PICK: begin
            kind_class = wsh_pkg::CMD_PICK;
         end
         default: begin
            kind_class = wsh_pkg::CMD_REJECT;
         end
      endcase
   end

   // queue handshake
   assign req_tready = (fill_ff != (wsh_pkg::QPTR_BITS + 1)'(wsh_pkg::QUEUE_DEPTH));
   assign push       = req_tvalid && req_tready;
   assign cmd.valid  = (fill_ff != '0);
   assign cmd.kind   = kind_mem[rd_ptr_ff];
   assign cmd_data   = data_mem[rd_ptr_ff];
   assign pop        = cmd.valid && cmd_ready;

   // pointer and fill update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == wsh_pkg::QPTR_BITS'(wsh_pkg::QUEUE_DEPTH - 1))
                     ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == wsh_pkg::QPTR_BITS'(wsh_pkg::QUEUE_DEPTH - 1))
                     ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         kind_mem[wr_ptr_ff] <= kind_class;
         data_mem[wr_ptr_ff] <= req_data;
      end
   end

endmodule
`default_nettype wire

// ----- rtl/wsh_back.sv -----
`default_nettype none
module wsh_back #(
   parameter int MAX_WINDOWS = 8,
   parameter int COORD_BITS  = 12,
   localparam int ID_BITS    = $clog2(MAX_WINDOWS),
   localparam int CNT_BITS   = $clog2(MAX_WINDOWS + 1),
   localparam int DATA_W     = ID_BITS + 6 * COORD_BITS + 2
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic [CNT_BITS-1:0]      live_count,
   input  wire wsh_pkg::cmd_ctrl_type    cmd,
   input  wire logic [DATA_W-1:0]        cmd_data,
   output logic                          cmd_ready,
   output logic                          rsp_valid,
   input  wire logic                     rsp_ready,
   output wsh_pkg::rsp_flags_type        rsp_flags,
   output logic [ID_BITS-1:0]            rsp_hit_window,
   output logic [ID_BITS-1:0]            rsp_top_window
);

   localparam int CB   = COORD_BITS;
   localparam int SB   = COORD_BITS + 1;
   localparam int EB   = COORD_BITS + 2;
   localparam int X_LO = ID_BITS;
   localparam int Y_LO = X_LO + CB;
   localparam int L_LO = Y_LO + CB;
   localparam int T_LO = L_LO + SB;
   localparam int W_LO = T_LO + SB;
   localparam int H_LO = W_LO + CB;

   // window state
   logic [ID_BITS-1:0]     order_ff  [MAX_WINDOWS];
   logic signed [SB-1:0]   left_ff   [MAX_WINDOWS];
   logic signed [SB-1:0]   top_ff    [MAX_WINDOWS];
   logic [CB-1:0]          width_ff  [MAX_WINDOWS];
   logic [CB-1:0]          height_ff [MAX_WINDOWS];
   logic [MAX_WINDOWS-1:0] valid_ff;

   // search state
   wsh_pkg::back_state_type state_ff, state_in;
   logic [CNT_BITS-1:0]     slot_ff;
   logic [CB-1:0]           px_ff, py_ff;

   // result register
   logic                    rsp_valid_ff;
   wsh_pkg::rsp_flags_type  flags_ff, flags_in;
   logic [ID_BITS-1:0]      hit_win_ff, hit_win_in;
   logic [ID_BITS-1:0]      top_win_ff, top_win_in;

   // control
   logic                    slot_free, frame_we, pick_start, slot_dec, raise, rsp_load;
   logic [ID_BITS-1:0]      cmd_id, top_idx, top_now, probe_idx, probe_win;
   logic [CNT_BITS-1:0]     probe_slot;
   logic signed [EB-1:0]    p_left, p_top, p_right, p_bottom, pt_x, pt_y;
   logic                    probe_hold;

   assign cmd_id = cmd_data[ID_BITS-1:0];

   // current top of the stack
   assign top_idx = ID_BITS'(live_count - 1'b1);
   assign top_now = (live_count != '0) ? order_ff[top_idx] : '0;

   // slot being probed and its rectangle, unwritten windows read as empty
   assign probe_slot = slot_ff - 1'b1;
   assign probe_idx  = ID_BITS'(probe_slot);
   assign probe_win  = order_ff[probe_idx];

   always_comb begin
      if (valid_ff[probe_win]) begin
         p_left   = EB'(left_ff[probe_win]);
         p_top    = EB'(top_ff[probe_win]);
         p_right  = EB'(left_ff[probe_win]) + $signed({2'b00, width_ff[probe_win]});
         p_bottom = EB'(top_ff[probe_win]) + $signed({2'b00, height_ff[probe_win]});
      end else begin
         p_left   = '0;
         p_top    = '0;
         p_right  = '0;
         p_bottom = '0;
      end
   end

   // half-open containment test
   assign pt_x = $signed({2'b00, px_ff});
   assign pt_y = $signed({2'b00, py_ff});
   assign probe_hold = (pt_x >= p_left) && (pt_x < p_right) &&
                       (pt_y >= p_top) && (pt_y < p_bottom);

   assign slot_free = !rsp_valid_ff || rsp_ready;

   // sequencer next state and controls
   always_comb begin
      state_in   = state_ff;
      cmd_ready  = 1'b0;
      frame_we   = 1'b0;
      pick_start = 1'b0;
      slot_dec   = 1'b0;
      raise      = 1'b0;
      rsp_load   = 1'b0;
      flags_in   = '0;
      hit_win_in = '0;
      top_win_in = top_now;
      case (state_ff)
         wsh_pkg::BK_IDLE: begin
            if (cmd.valid) begin
               case (cmd.kind)
                  wsh_pkg::CMD_FRAME: begin
                     if (slot_free) begin
                        cmd_ready = 1'b1;
                        frame_we  = 1'b1;
                        rsp_load  = 1'b1;
                     end
                  end
                  wsh_pkg::CMD_PICK: begin
                     cmd_ready  = 1'b1;
                     pick_start = 1'b1;
                     state_in   = wsh_pkg::BK_SEARCH;
                  end
                  default: begin
                     if (slot_free) begin
                        cmd_ready         = 1'b1;
                        rsp_load          = 1'b1;
                        flags_in.rejected = 1'b1;
                     end
                  end
               endcase
            end
         end
         wsh_pkg::BK_SEARCH: begin
            if (slot_ff == '0) begin
               if (slot_free) begin
                  rsp_load = 1'b1;
                  state_in = wsh_pkg::BK_IDLE;
               end
            end else if (probe_hold) begin
               if (slot_free) begin
                  raise        = 1'b1;
                  rsp_load     = 1'b1;
                  flags_in.hit = 1'b1;
                  hit_win_in   = probe_win;
                  top_win_in   = probe_win;
                  state_in     = wsh_pkg::BK_IDLE;
               end
            end else begin
               slot_dec = 1'b1;
            end
         end
         default: begin
            state_in = wsh_pkg::BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= wsh_pkg::BK_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // search counter and captured pointer
   always_ff @(posedge clock) begin
      if (pick_start) begin
         slot_ff <= live_count;
         px_ff   <= cmd_data[Y_LO-1:X_LO];
         py_ff   <= cmd_data[L_LO-1:Y_LO];
      end else if (slot_dec) begin
         slot_ff <= probe_slot;
      end
   end

   // stacking order, raise shifts the slots above the hit down by one
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < MAX_WINDOWS; k++) begin
            order_ff[k] <= ID_BITS'(k);
         end
      end else if (raise) begin
         for (int k = 0; k < MAX_WINDOWS; k++) begin
            if (k == 32'(live_count) - 1) begin
               order_ff[k] <= probe_win;
            end else if ((k >= 32'(probe_slot)) && (k < 32'(live_count) - 1)) begin
               order_ff[k] <= order_ff[(k + 1) % MAX_WINDOWS];
            end
         end
      end
   end

   // window rectangles
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (frame_we) begin
         valid_ff[cmd_id] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (frame_we) begin
         left_ff[cmd_id]   <= $signed(cmd_data[T_LO-1:L_LO]);
         top_ff[cmd_id]    <= $signed(cmd_data[W_LO-1:T_LO]);
         width_ff[cmd_id]  <= cmd_data[H_LO-1:W_LO];
         height_ff[cmd_id] <= cmd_data[DATA_W-1:H_LO];
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         flags_ff   <= flags_in;
         hit_win_ff <= hit_win_in;
         top_win_ff <= top_win_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_flags      = flags_ff;
   assign rsp_hit_window = hit_win_ff;
   assign rsp_top_window = top_win_ff;

endmodule
`default_nettype wire
